FILE: design/flow_table_counter_expiry_core_macros.svh
// assertion macros shared by the flow table design files
// no dependencies
`ifndef FLOW_TABLE_COUNTER_EXPIRY_CORE_MACROS_SVH
`define FLOW_TABLE_COUNTER_EXPIRY_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define FTCE_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define FTCE_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

FILE: design/ftce_pkg.sv
// shared types and constants for the flow table counter expiry core
// no dependencies
package ftce_pkg;
	localparam logic [1:0] ST_HIT   = 2'd0;
	localparam logic [1:0] ST_NEW   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_SWEEP = 2'd3;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [31:0] EXPIRE_RESET = 32'd300;
	localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;
	localparam logic [39:0] BYTE_MAX = 40'hFF_FFFF_FFFF;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the item
		logic scan_rd;  // issue a read at the scan index
		logic scan_chk; // check registered read data
		logic idx_clr;
		logic finish;   // write back and report
	} ftce_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_idx; // read issued this cycle is at the last entry
	} ftce_sts_t;
endpackage

FILE: design/ftce_datapath.sv
// table storage, scan compare, counter update and result register
// depends on ftce_pkg and the macros header
`include "flow_table_counter_expiry_core_macros.svh"
module ftce_datapath #(
	parameter int FLOW_ENTRIES = 64,
	parameter int IDX_W = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  ftce_pkg::ftce_cmd_t cmd,
	output ftce_pkg::ftce_sts_t sts,
	input  logic [31:0] expire_seconds,
	input  logic        kind,
	input  logic [7:0]  protocol,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port_raw,
	input  logic [15:0] dst_port_raw,
	input  logic [15:0] packet_length,
	input  logic [31:0] now_sec,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  flow_slot,
	output logic [31:0] packet_count,
	output logic [39:0] byte_count,
	output logic [31:0] first_seen,
	output logic [6:0]  expired_count
);
	import ftce_pkg::*;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] ports;
		logic [31:0] pkts;
		logic [39:0] bytes;
		logic [31:0] created;
		logic [31:0] last;
	} entry_t;

	entry_t mem [FLOW_ENTRIES];
	logic [FLOW_ENTRIES-1:0] valid_q;

	logic        kind_q;
	logic [31:0] src_q, dst_q, ports_q, now_q, limit_q;
	logic [15:0] len_q;
	logic [IDX_W:0] idx_q;
	logic [IDX_W-1:0] chk_idx_s1;
	entry_t rd_s1;
	logic   rd_vld_s1;
	logic   hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	entry_t hit_e_q;
	logic [6:0] gone_q;
	logic   wr_en;
	logic [IDX_W-1:0] wr_idx;
	entry_t wr_e;
	logic   match, stale;
	logic [32:0] pk_inc;
	logic [40:0] by_sum;
	logic [31:0] pk_new;
	logic [39:0] by_new;

	assign sts.last_idx = (idx_q == (IDX_W+1)'(FLOW_ENTRIES - 1));

	assign match = rd_vld_s1 && rd_s1.src == src_q && rd_s1.dst == dst_q
		&& rd_s1.ports == ports_q;
	assign stale = rd_vld_s1 && (rd_s1.last <= limit_q);

	assign pk_inc = {1'b0, hit_e_q.pkts} + 33'd1;
	assign pk_new = pk_inc[32] ? PKT_MAX : pk_inc[31:0];
	assign by_sum = {1'b0, hit_e_q.bytes} + {25'd0, len_q};
	assign by_new = by_sum[40] ? BYTE_MAX : by_sum[39:0];

	always_comb begin
		wr_en = cmd.finish && !kind_q && (hit_q || free_q);
		wr_idx = hit_q ? hit_idx_q : free_idx_q;
		wr_e.src = src_q;
		wr_e.dst = dst_q;
		wr_e.ports = ports_q;
		wr_e.last = now_q;
		if (hit_q) begin
			wr_e.pkts = pk_new;
			wr_e.bytes = by_new;
			wr_e.created = hit_e_q.created;
		end else begin
			wr_e.pkts = 32'd1;
			wr_e.bytes = {24'd0, len_q};
			wr_e.created = now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_e;
		end
		rd_s1 <= mem[idx_q[IDX_W-1:0]];
		chk_idx_s1 <= idx_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			hit_e_q <= '0;
			gone_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
			rd_vld_s1 <= cmd.scan_rd && valid_q[idx_q[IDX_W-1:0]];
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.scan_rd) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.load) begin
				hit_q <= 1'b0;
				free_q <= 1'b0;
				gone_q <= '0;
			end
			if (cmd.scan_chk) begin
				if (kind_q) begin
					if (stale) begin
						valid_q[chk_idx_s1] <= 1'b0;
						if (gone_q != 7'd127) begin
							gone_q <= gone_q + 7'd1;
						end
					end
				end else if (!hit_q) begin
					if (match) begin
						hit_q <= 1'b1;
						hit_idx_q <= chk_idx_s1;
						hit_e_q <= rd_s1;
					end else if (!rd_vld_s1 && !valid_q[chk_idx_s1] && !free_q) begin
						free_q <= 1'b1;
						free_idx_q <= chk_idx_s1;
					end
				end
			end
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	// item capture; ports forced unless tcp or udp
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			src_q <= src_addr;
			dst_q <= dst_addr;
			if (protocol == PROTO_TCP || protocol == PROTO_UDP) begin
				ports_q <= {src_port_raw, dst_port_raw};
			end else begin
				ports_q <= 32'hFFFF_FFFF;
			end
			len_q <= packet_length;
			now_q <= now_sec;
			limit_q <= now_sec - expire_seconds;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (kind_q) begin
				status <= ST_SWEEP;
				flow_slot <= '0;
				packet_count <= '0;
				byte_count <= '0;
				first_seen <= '0;
				expired_count <= gone_q;
			end else if (hit_q || free_q) begin
				status <= hit_q ? ST_HIT : ST_NEW;
				flow_slot <= 6'(wr_idx);
				packet_count <= wr_e.pkts;
				byte_count <= wr_e.bytes;
				first_seen <= wr_e.created;
				expired_count <= '0;
			end else begin
				status <= ST_FULL;
				flow_slot <= '0;
				packet_count <= '0;
				byte_count <= '0;
				first_seen <= '0;
				expired_count <= '0;
			end
		end
	end

	`FTCE_ASSERT_NEXT(a_done_follows, clk, arst_n, cmd.finish, done, "done lost")
	`FTCE_ASSERT_IMP(a_no_write_sweep, clk, arst_n, kind_q && cmd.finish, !wr_en,
		"sweep wrote table")
	`FTCE_ASSERT_IMP(a_gone_sat, clk, arst_n, 1'b1, gone_q <= 7'd127, "gone overflow")
endmodule

FILE: design/ftce_ctrl.sv
// scan controller: sequences capture, table scan and report
// depends on ftce_pkg and the macros header
`include "flow_table_counter_expiry_core_macros.svh"
module ftce_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output ftce_pkg::ftce_cmd_t cmd,
	input  ftce_pkg::ftce_sts_t sts
);
	import ftce_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_TAIL = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q, state_d;
	logic chk_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.scan_chk = chk_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.last_idx) state_d = S_TAIL;
			end
			S_TAIL: state_d = S_FIN;
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_q <= cmd.scan_rd;
		end
	end

	`FTCE_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "start not taken")
	`FTCE_ASSERT_IMP(a_fin_once, clk, arst_n, cmd.finish, !cmd.scan_rd, "finish in scan")
	`FTCE_ASSERT_IMP(a_idle_quiet, clk, arst_n, !busy, !cmd.scan_chk && !cmd.finish,
		"activity when idle")
endmodule

FILE: design/flow_table_counter_expiry_core.sv
// top level of the flow table counter expiry core
// depends on ftce_pkg, ftce_ctrl and ftce_datapath
// Each item (packet or sweep) scans the whole table memory, one entry a cycle, before
// the done strobe; busy drops the cycle after done, and a new start is taken only
// while busy is low. The result is registered onto the outputs in the cycle in which
// done is high, held until the next item finishes, and done cannot be held off.
// expire_seconds_we may be used only while busy is low.
module flow_table_counter_expiry_core #(
	parameter int FLOW_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        expire_seconds_we,
	input  logic [31:0] expire_seconds_wdata,
	input  logic        kind,
	input  logic [7:0]  protocol,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port_raw,
	input  logic [15:0] dst_port_raw,
	input  logic [15:0] packet_length,
	input  logic [31:0] now_sec,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  flow_slot,
	output logic [31:0] packet_count,
	output logic [39:0] byte_count,
	output logic [31:0] first_seen,
	output logic [6:0]  expired_count
);
	import ftce_pkg::*;

	localparam int IDX_W = $clog2(FLOW_ENTRIES);

	logic [31:0] expire_q;
	ftce_cmd_t cmd;
	ftce_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expire_q <= EXPIRE_RESET;
		end else if (expire_seconds_we) begin
			expire_q <= expire_seconds_wdata;
		end
	end

	ftce_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
	);

	ftce_datapath #(.FLOW_ENTRIES(FLOW_ENTRIES), .IDX_W(IDX_W)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.expire_seconds(expire_q), .kind(kind), .protocol(protocol),
		.src_addr(src_addr), .dst_addr(dst_addr), .src_port_raw(src_port_raw),
		.dst_port_raw(dst_port_raw), .packet_length(packet_length),
		.now_sec(now_sec), .done(done), .status(status), .flow_slot(flow_slot),
		.packet_count(packet_count), .byte_count(byte_count),
		.first_seen(first_seen), .expired_count(expired_count)
	);
endmodule
